### sv/lfsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsc_pkg: shared definitions for the function flag cache
// Field widths of the command and result words, and the controller states.
// ----------------------------------------------------------------------------
package lfsc_pkg;

  // fixed widths of the command and result word fields
  localparam int ADDR_FIELD_W = 14;
  localparam int FUNC_W       = 5;
  localparam int VALUE_W      = 8;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } lfsc_state_t;

endpackage : lfsc_pkg

### sv/lru_function_state_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_function_state_cache_top: move-to-front function flag cache
// Fully associative cache of per-address flag words in a chain of cells.
// ----------------------------------------------------------------------------
// A command word is captured into a holding register and then looked up:
// every cell compares its tag in parallel, the matching flag word is gathered
// along the chain, the flag is updated or read, and the chain shifts so that
// the entry lands at the head (a miss shifts the whole chain and drops the tail
// entry when full). The result word is loaded into an output register at the
// lookup. A new command is taken only once the previous lookup is done; the
// lookup step waits while the previous result is still stalled, and the input
// stalls during the lookup step. Entry valid bits clear at reset, no clearing pass.
// ----------------------------------------------------------------------------
module lru_function_state_cache_top #(
  parameter int ENTRIES      = 16,
  parameter int FLAG_BITS    = 32,
  parameter int FUNC_BASE    = 0,
  parameter int ADDRESS_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [lfsc_pkg::ADDR_FIELD_W-1:0]    in_target_address,
  input  logic [lfsc_pkg::FUNC_W-1:0]          in_function_number,
  input  logic                                 in_new_state,
  input  logic [lfsc_pkg::VALUE_W-1:0]         in_value_when_on,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_changed,
  output logic [lfsc_pkg::VALUE_W-1:0]         out_read_value
);
  import lfsc_pkg::*;

  localparam int TAG_W = (ADDRESS_BITS < ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;

  lfsc_state_t state_r, state_nxt;

  logic               kind_r;
  logic [TAG_W-1:0]   tag_r;
  logic [FUNC_W-1:0]  func_r;
  logic               new_state_r;
  logic [VALUE_W-1:0] value_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_changed_r;
  logic [VALUE_W-1:0] out_read_value_r;

  logic               capture;
  logic               commit;

  logic                 link_valid [0:ENTRIES];
  logic [TAG_W-1:0]     link_tag   [0:ENTRIES];
  logic [FLAG_BITS-1:0] link_flags [0:ENTRIES];
  logic                 hit_before [0:ENTRIES];
  logic [FLAG_BITS-1:0] acc        [0:ENTRIES];
  logic [ENTRIES-1:0]   valid_vec;
  logic [ENTRIES-1:0]   hit_vec;

  logic [FLAG_BITS-1:0] new_flags;
  logic                 op_changed;
  logic [VALUE_W-1:0]   op_read_value;

  // controller: next state, handshake and output valid
  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    capture       = 1'b0;
    commit        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          capture   = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_r || !out_stall) begin
          commit        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the command word for the lookup step
  always_ff @(posedge clk) begin
    if (capture) begin
      kind_r      <= in_kind;
      tag_r       <= in_target_address[TAG_W-1:0];
      func_r      <= in_function_number;
      new_state_r <= in_new_state;
      value_r     <= in_value_when_on;
    end
  end

  // head of the chain: the looked-up entry re-enters as most recent
  assign link_valid[0] = 1'b1;
  assign link_tag[0]   = tag_r;
  assign link_flags[0] = new_flags;
  assign hit_before[0] = 1'b0;
  assign acc[0]        = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfsc_cell #(
      .TAG_W     (TAG_W),
      .FLAG_BITS (FLAG_BITS)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .commit         (commit),
      .cmp_tag        (tag_r),
      .prev_valid     (link_valid[i]),
      .prev_tag       (link_tag[i]),
      .prev_flags     (link_flags[i]),
      .hit_before_in  (hit_before[i]),
      .acc_in         (acc[i]),
      .valid          (link_valid[i+1]),
      .tag            (link_tag[i+1]),
      .flags          (link_flags[i+1]),
      .hit            (hit_vec[i]),
      .hit_before_out (hit_before[i+1]),
      .acc_out        (acc[i+1])
    );
    assign valid_vec[i] = link_valid[i+1];
  end

  // update or read the flag; a miss starts from a cleared word
  lfsc_flag_op #(
    .FLAG_BITS (FLAG_BITS),
    .FUNC_BASE (FUNC_BASE)
  ) u_flag_op (
    .kind       (kind_r),
    .new_state  (new_state_r),
    .func       (func_r),
    .value      (value_r),
    .flags_in   (acc[ENTRIES]),
    .flags_out  (new_flags),
    .changed    (op_changed),
    .read_value (op_read_value)
  );

  // load the result word
  always_ff @(posedge clk) begin
    if (commit) begin
      out_changed_r    <= op_changed;
      out_read_value_r <= op_read_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_changed    = out_changed_r;
  assign out_read_value = out_read_value_r;

  // valid entries always sit packed at the head of the chain
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("cache entries not packed at head of chain");

  // tags are unique among valid entries
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cache entry matches");

  // a committed lookup leaves its entry at the head, matching the held tag
  a_head_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> valid_vec[0] && hit_vec[0])
    else $error("looked-up entry not at head of chain");

  // a result is produced only by a lookup step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(commit))
    else $error("result word without lookup");

endmodule : lru_function_state_cache_top

### sv/lfsc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsc_cell: one slot of the move-to-front chain
// Holds one tag and flag word, compares the tag against the lookup address
// and takes its predecessor's entry when the chain shifts past it.
// ----------------------------------------------------------------------------
module lfsc_cell #(
  parameter int TAG_W     = 14,
  parameter int FLAG_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 commit,
  input  logic [TAG_W-1:0]     cmp_tag,
  input  logic                 prev_valid,
  input  logic [TAG_W-1:0]     prev_tag,
  input  logic [FLAG_BITS-1:0] prev_flags,
  input  logic                 hit_before_in,
  input  logic [FLAG_BITS-1:0] acc_in,
  output logic                 valid,
  output logic [TAG_W-1:0]     tag,
  output logic [FLAG_BITS-1:0] flags,
  output logic                 hit,
  output logic                 hit_before_out,
  output logic [FLAG_BITS-1:0] acc_out
);

  logic                 valid_r;
  logic [TAG_W-1:0]     tag_r;
  logic [FLAG_BITS-1:0] flags_r;
  logic                 shift;

  // compare against the lookup address and pass the match on down the chain
  assign hit            = valid_r && (tag_r == cmp_tag);
  assign hit_before_out = hit_before_in | hit;
  assign acc_out        = acc_in | (hit ? flags_r : '0);

  // shift only while no match has been seen closer to the head
  assign shift = commit && !hit_before_in;

  // hold or take the neighbour's entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      tag_r   <= prev_tag;
      flags_r <= prev_flags;
    end
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign flags = flags_r;

endmodule : lfsc_cell

### sv/lfsc_flag_op.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsc_flag_op: single flag update and read
// Sets, clears or tests one flag of the selected entry's flag word.
// ----------------------------------------------------------------------------
module lfsc_flag_op #(
  parameter int FLAG_BITS = 32,
  parameter int FUNC_BASE = 0
) (
  input  logic                          kind,
  input  logic                          new_state,
  input  logic [lfsc_pkg::FUNC_W-1:0]   func,
  input  logic [lfsc_pkg::VALUE_W-1:0]  value,
  input  logic [FLAG_BITS-1:0]          flags_in,
  output logic [FLAG_BITS-1:0]          flags_out,
  output logic                          changed,
  output logic [lfsc_pkg::VALUE_W-1:0]  read_value
);
  import lfsc_pkg::*;

  localparam int IDX_W = FUNC_W + 1;

  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  logic [FLAG_BITS-1:0] mask;
  logic                 cur;

  // locate the flag; out-of-range numbers touch nothing
  assign idx      = {1'b0, func} - IDX_W'(FUNC_BASE);
  assign in_range = ({1'b0, func} >= IDX_W'(FUNC_BASE)) && (int'(idx) < FLAG_BITS);
  assign mask     = in_range ? ({{(FLAG_BITS-1){1'b0}}, 1'b1} << idx) : '0;
  assign cur      = |(flags_in & mask);

  // apply the update or the read
  always_comb begin
    flags_out  = flags_in;
    changed    = 1'b0;
    read_value = '0;
    if (!kind) begin
      flags_out = new_state ? (flags_in | mask) : (flags_in & ~mask);
      changed   = in_range && (new_state != cur);
    end else if (cur) begin
      read_value = value;
    end
  end

endmodule : lfsc_flag_op

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the move-to-front function flag cache
// Drives command words with random gaps, stalls the result side at random
// (once for a long stretch, so the result is held and the cache stalls its input),
// and checks each result word against a directed expectation or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_top;
  import lfsc_pkg::*;

  localparam int N_ENTRIES    = 16;
  localparam int N_FLAGS      = 32;
  localparam int FLAG_OFFSET  = 0;
  localparam int TAG_BITS     = 14;
  localparam int RANDOM_WORDS = 850;
  localparam int POOL_SIZE    = 20;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AFTER   = 300;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_READ   = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [ADDR_FIELD_W-1:0]   address;
    logic [FUNC_W-1:0]         func;
    logic                      new_state;
    logic [VALUE_W-1:0]        on_value;
  } flag_cmd_t;

  typedef struct packed {
    logic                      changed;
    logic [VALUE_W-1:0]        read_value;
  } flag_result_t;

  typedef struct packed {
    flag_cmd_t                 cmd;
    logic                      typed;
    flag_result_t              want;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_kind = 1'b0;
  logic [ADDR_FIELD_W-1:0] in_target_address = '0;
  logic [FUNC_W-1:0]       in_function_number = '0;
  logic                    in_new_state = 1'b0;
  logic [VALUE_W-1:0]      in_value_when_on = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_changed;
  logic [VALUE_W-1:0]      out_read_value;

  // model copy of the cache
  logic [TAG_BITS-1:0]     cache_tag   [N_ENTRIES];
  logic                    cache_live  [N_ENTRIES];
  logic [N_FLAGS-1:0]      cache_flags [N_ENTRIES];
  int                      cache_rank  [N_ENTRIES];

  flag_result_t            awaiting_flag_results[$];
  directed_row_t           directed_rows[$];
  logic [ADDR_FIELD_W-1:0] address_pool[POOL_SIZE];
  int                      error_count = 0;
  int                      words_taken = 0;
  int                      quiet_cycles = 0;
  bit                      burst_mode = 1'b0;

  lru_function_state_cache_top #(
    .ENTRIES      (N_ENTRIES),
    .FLAG_BITS    (N_FLAGS),
    .FUNC_BASE    (FLAG_OFFSET),
    .ADDRESS_BITS (TAG_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_target_address  (in_target_address),
    .in_function_number (in_function_number),
    .in_new_state       (in_new_state),
    .in_value_when_on   (in_value_when_on),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_changed        (out_changed),
    .out_read_value     (out_read_value)
  );

  always #2 clk = ~clk;

  // make entry e most recent; entries more recent than rank r move down one
  function automatic void move_to_front(int e, int r);
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (cache_live[i] && i != e && cache_rank[i] < r) cache_rank[i]++;
    end
    cache_rank[e] = 0;
  endfunction

  // hit, else lowest free entry, else recycle the least recent one
  function automatic int claim_entry(logic [TAG_BITS-1:0] tag);
    int count;
    int free_slot;
    int victim;
    int worst;
    count = 0;
    free_slot = -1;
    victim = 0;
    worst = 0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (cache_live[i]) begin
        count++;
        if (cache_tag[i] == tag) begin
          move_to_front(i, cache_rank[i]);
          return i;
        end
        if (cache_rank[i] >= worst) begin
          worst = cache_rank[i];
          victim = i;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (free_slot >= 0) begin
      cache_live[free_slot] = 1'b1;
      cache_tag[free_slot] = tag;
      cache_flags[free_slot] = '0;
      move_to_front(free_slot, count);
      return free_slot;
    end
    cache_tag[victim] = tag;
    cache_flags[victim] = '0;
    move_to_front(victim, worst);
    return victim;
  endfunction

  function automatic flag_result_t predict_flag_access(flag_cmd_t c);
    flag_result_t r;
    int           e;
    int           idx;
    logic         cur;
    r = '0;
    e = claim_entry(c.address[TAG_BITS-1:0]);
    idx = int'(c.func) - FLAG_OFFSET;
    if (idx >= 0 && idx < N_FLAGS) begin
      cur = cache_flags[e][idx];
      if (c.kind == KIND_UPDATE) begin
        if (c.new_state != cur) begin
          cache_flags[e][idx] = c.new_state;
          r.changed = 1'b1;
        end
      end else if (cur) begin
        r.read_value = c.on_value;
      end
    end
    return r;
  endfunction

  function automatic directed_row_t row(cmd_kind_t k, int a, int f, bit ns, int v,
                                        bit typed, bit ch, int rv);
    directed_row_t d;
    d.cmd.kind = k;
    d.cmd.address = a[ADDR_FIELD_W-1:0];
    d.cmd.func = f[FUNC_W-1:0];
    d.cmd.new_state = ns;
    d.cmd.on_value = v[VALUE_W-1:0];
    d.typed = typed;
    d.want.changed = ch;
    d.want.read_value = rv[VALUE_W-1:0];
    return d;
  endfunction

  // mostly short gaps, a few long ones, none at all in burst stretches
  function automatic int pick_gap();
    int p;
    if (burst_mode) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic flag_cmd_t random_cmd();
    flag_cmd_t c;
    c.kind = cmd_kind_t'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85) c.address = address_pool[$urandom_range(0, POOL_SIZE - 1)];
    else c.address = ADDR_FIELD_W'($urandom_range(0, (1 << ADDR_FIELD_W) - 1));
    c.func = FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1));
    c.new_state = 1'($urandom_range(0, 1));
    c.on_value = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
    return c;
  endfunction

  // offer one word from a falling edge; return at the falling edge after it is taken
  task automatic offer_word(flag_cmd_t c, bit typed, flag_result_t want);
    int           gap;
    flag_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= c.kind;
    in_target_address <= c.address;
    in_function_number <= c.func;
    in_new_state <= c.new_state;
    in_value_when_on <= c.on_value;
    do @(posedge clk); while (in_stall);
    r = predict_flag_access(c);
    awaiting_flag_results.push_back(typed ? want : r);
    words_taken++;
    @(negedge clk);
  endtask

  // directed table, then random words with reuse of a small address pool
  initial begin
    flag_result_t none;
    none = '0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      cache_live[i] = 1'b0;
      cache_tag[i] = '0;
      cache_flags[i] = '0;
      cache_rank[i] = 0;
    end
    directed_rows = '{
      row(KIND_READ,   0,     0,  0, 255, 1, 0, 0),
      row(KIND_UPDATE, 0,     0,  1, 0,   1, 1, 0),
      row(KIND_UPDATE, 0,     0,  1, 0,   1, 0, 0),
      row(KIND_READ,   0,     0,  0, 255, 1, 0, 255),
      row(KIND_UPDATE, 16383, 31, 1, 0,   1, 1, 0),
      row(KIND_READ,   16383, 31, 1, 165, 1, 0, 165),
      row(KIND_UPDATE, 16383, 31, 0, 255, 1, 1, 0),
      row(KIND_UPDATE, 0,     31, 0, 0,   1, 0, 0)
    };
    // fill the remaining entries, each a fresh flag word
    for (int a = 1; a <= N_ENTRIES - 2; a++) begin
      directed_rows.push_back(row(KIND_UPDATE, a, a, 1, 0, 1, 1, 0));
    end
    // full cache: recycle the tail, then check the recycled entry is not next out
    directed_rows.push_back(row(KIND_UPDATE, 100, 3, 1, 0,  1, 1, 0));
    directed_rows.push_back(row(KIND_UPDATE, 200, 7, 1, 0,  1, 1, 0));
    directed_rows.push_back(row(KIND_READ,   100, 3, 0, 60, 1, 0, 60));
    directed_rows.push_back(row(KIND_READ,   1,   1, 0, 90, 0, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int i = 0; i < POOL_SIZE; i++) address_pool[i] = ADDR_FIELD_W'($urandom);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // refresh part of the pool now and then; switch burst stretches on and off
      if (n % 60 == 0) begin
        burst_mode = ($urandom_range(0, 99) < 30);
        for (int k = 0; k < 3; k++) begin
          address_pool[$urandom_range(0, POOL_SIZE - 1)] = ADDR_FIELD_W'($urandom);
        end
      end
      offer_word(random_cmd(), 1'b0, none);
    end
    in_valid <= 1'b0;

    // drain, then let trailing words show up
    while (awaiting_flag_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side stall: short and long holds, free-running stretches, one long hold-off
  initial begin
    int  len;
    bit  held_off;
    held_off = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_off && words_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        len = HOLD_CYCLES;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            out_stall <= 1'b0;
            len = $urandom_range(1, 4);
          end
          4, 5: begin
            out_stall <= 1'b1;
            len = $urandom_range(1, 3);
          end
          6: begin
            out_stall <= 1'b1;
            len = $urandom_range(10, 60);
          end
          default: begin
            out_stall <= 1'b0;
            len = $urandom_range(20, 60);
          end
        endcase
      end
      repeat (len) @(negedge clk);
    end
  end

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    flag_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaiting_flag_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word, expected none, actual changed=%0d read=%0d",
                 $time, out_changed, out_read_value);
      end else begin
        want = awaiting_flag_results.pop_front();
        if (out_changed !== want.changed) begin
          error_count++;
          $display("%0t: changed mismatch, expected %0d, actual %0d",
                   $time, want.changed, out_changed);
        end
        if (out_read_value !== want.read_value) begin
          error_count++;
          $display("%0t: read_value mismatch, expected %0d, actual %0d",
                   $time, want.read_value, out_read_value);
        end
      end
    end
  end

  // end the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, awaiting_flag_results.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### files.f
sv/lfsc_pkg.sv
sv/lfsc_cell.sv
sv/lfsc_flag_op.sv
sv/lru_function_state_cache_top.sv
tb/sv/tb_top.sv
